// ----- hdl/lzss_window_decompressor_top_assert.svh -----
// ----------------------------------------------------------------------------
// LZSS window decompressor assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LZSS_WINDOW_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZSS_WINDOW_DECOMPRESSOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LZWD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LZWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// LZSS window decompressor package
// Shared types and fixed constants of the compressed stream format.
// ----------------------------------------------------------------------------
package lzwd_pkg;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_ITEM,
        PH_REF2
    } phase_t;

    localparam int          OFFSET_W  = 12;
    localparam int          REM_W     = 5;
    localparam logic [2:0]  LAST_TAG  = 3'd7;
    localparam byte_t       END_BYTE  = 8'h00;

endpackage

// ----- hdl/lzwd_in_if.sv -----
// ----------------------------------------------------------------------------
// LZSS decompressor input channel
// Compressed byte stream with a chunk start mark, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lzwd_in_if
    import lzwd_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  chunk_start;

    modport source (output valid, output in_byte, output chunk_start, input ready);
    modport sink   (input valid, input in_byte, input chunk_start, output ready);
endinterface

// ----- hdl/lzwd_out_if.sv -----
// ----------------------------------------------------------------------------
// LZSS decompressor output channel
// Decompressed bytes and end marks, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lzwd_out_if
    import lzwd_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  end_marker;
    logic  run_last;

    modport source (output valid, output out_byte, output end_marker, output run_last,
                    input ready);
    modport sink   (input valid, input out_byte, input end_marker, input run_last,
                    output ready);
endinterface

// ----- hdl/lzss_window_decompressor_top.sv -----
// ----------------------------------------------------------------------------
// LZSS window decompressor
// Expands a flag/literal/reference byte stream through a 4 KB history window.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one compressed byte per request; chunk_start marks the flag
//   byte of a new chunk. out_ch carries decompressed bytes, an end result
//   (end_marker set, out_byte zero) when a zero-offset reference closes the
//   chunk, and run_last on the final result caused by one input byte.
//   Flag bytes, first reference bytes and ignored bytes produce no output.
//   A literal shows on out_ch in the cycle after it is accepted.
//   A reference reads the window RAM one byte per cycle while out_ch does
//   not stall; each byte passes the RAM read data register and then the
//   output register, and the single RAM read port sets that rate.
//   After reset the window is zeroed by a pass over all WINDOW_DEPTH entries,
//   one entry a cycle, during which in_ch.ready stays low.
//   When out_ch stalls, the pending byte is held and the copy pauses; no input
//   is taken until the output register can be loaded.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_top
    import lzwd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4096
)
(
    input  logic              clk,
    input  logic              rst_n,
    lzwd_in_if.sink           in_ch,
    lzwd_out_if.source        out_ch
);

    localparam int            AW        = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] WP_START  = AW'(1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);

    // parser state
    phase_t             phase_reg, phase_next;
    byte_t              flag_bits_reg, flag_bits_next;
    logic [2:0]         flag_pos_reg, flag_pos_next;
    byte_t              first_ref_reg, first_ref_next;
    logic               finished_reg, finished_next;
    logic [AW-1:0]      wp_reg, wp_next;

    // clearing pass
    logic               clr_active_reg, clr_active_next;
    logic [AW-1:0]      clr_addr_reg, clr_addr_next;

    // copy engine
    logic               rd_pend_reg, rd_pend_next;
    logic               hold_valid_reg, hold_valid_next;
    byte_t              hold_reg, hold_next;
    logic               fwd_hit_reg, fwd_hit_next;
    byte_t              fwd_data_reg, fwd_data_next;
    logic [AW-1:0]      copy_off_reg, copy_off_next;
    logic [REM_W-1:0]   copy_rem_reg, copy_rem_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    byte_t              out_byte_reg, out_byte_next;
    logic               out_end_reg, out_end_next;
    logic               out_last_reg, out_last_next;

    // window RAM port
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    byte_t              ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    byte_t              ram_rdata;

    logic               out_free;
    logic               busy;
    logic               in_ready;
    logic               in_acc;
    byte_t              byte_val;
    logic [OFFSET_W-1:0] ref_offset;

    lzwd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || out_ch.ready;
    assign busy       = rd_pend_reg || hold_valid_reg;
    assign in_ready   = !clr_active_reg && !busy && out_free;
    assign in_acc     = in_ch.valid && in_ready;
    assign byte_val   = hold_valid_reg ? hold_reg :
                        (fwd_hit_reg ? fwd_data_reg : ram_rdata);
    assign ref_offset = {in_ch.in_byte, first_ref_reg[7:4]};

    assign in_ch.ready       = in_ready;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.end_marker = out_end_reg;
    assign out_ch.run_last   = out_last_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        flag_bits_next  = flag_bits_reg;
        flag_pos_next   = flag_pos_reg;
        first_ref_next  = first_ref_reg;
        finished_next   = finished_reg;
        wp_next         = wp_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        rd_pend_next    = 1'b0;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        fwd_hit_next    = 1'b0;
        fwd_data_next   = fwd_data_reg;
        copy_off_next   = copy_off_reg;
        copy_rem_next   = copy_rem_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_byte_next   = out_byte_reg;
        out_end_next    = out_end_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = wp_reg;
        ram_wdata       = in_ch.in_byte;
        ram_re          = 1'b0;
        ram_raddr       = copy_off_reg;

        if (clr_active_reg)
        begin
            ram_we        = 1'b1;
            ram_waddr     = clr_addr_reg;
            ram_wdata     = END_BYTE;
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_active_next = 1'b0;
            end
        end
        else if (busy)
        begin
            if (out_free)
            begin
                ram_we          = 1'b1;
                ram_wdata       = byte_val;
                wp_next         = wp_reg + AW'(1);
                out_valid_next  = 1'b1;
                out_byte_next   = byte_val;
                out_end_next    = 1'b0;
                out_last_next   = (copy_rem_reg == '0);
                hold_valid_next = 1'b0;
                if (copy_rem_reg != '0)
                begin
                    ram_re        = 1'b1;
                    rd_pend_next  = 1'b1;
                    // RAM returns old data when reading the entry written now
                    fwd_hit_next  = (copy_off_reg == wp_reg);
                    fwd_data_next = byte_val;
                    copy_off_next = copy_off_reg + AW'(1);
                    copy_rem_next = copy_rem_reg - REM_W'(1);
                end
            end
            else
            begin
                // hold the byte until the output register frees up
                hold_valid_next = 1'b1;
                hold_next       = byte_val;
            end
        end
        else if (in_acc)
        begin
            if (in_ch.chunk_start)
            begin
                wp_next        = WP_START;
                flag_bits_next = in_ch.in_byte;
                flag_pos_next  = '0;
                phase_next     = PH_ITEM;
                finished_next  = 1'b0;
            end
            else if (!finished_reg)
            begin
                case (phase_reg)
                    PH_REF2:
                    begin
                        if (ref_offset == '0)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = END_BYTE;
                            out_end_next   = 1'b1;
                            out_last_next  = 1'b1;
                            finished_next  = 1'b1;
                            phase_next     = PH_FLAG;
                        end
                        else
                        begin
                            ram_re        = 1'b1;
                            ram_raddr     = AW'(ref_offset);
                            rd_pend_next  = 1'b1;
                            copy_off_next = AW'(ref_offset) + AW'(1);
                            copy_rem_next = {1'b0, first_ref_reg[3:0]} + REM_W'(1);
                            flag_pos_next = flag_pos_reg + 3'd1;
                            phase_next    = (flag_pos_reg == LAST_TAG) ? PH_FLAG : PH_ITEM;
                        end
                    end
                    PH_ITEM:
                    begin
                        if (!flag_bits_reg[flag_pos_reg])
                        begin
                            ram_we         = 1'b1;
                            wp_next        = wp_reg + AW'(1);
                            out_valid_next = 1'b1;
                            out_byte_next  = in_ch.in_byte;
                            out_end_next   = 1'b0;
                            out_last_next  = 1'b1;
                            flag_pos_next  = flag_pos_reg + 3'd1;
                            phase_next     = (flag_pos_reg == LAST_TAG) ? PH_FLAG : PH_ITEM;
                        end
                        else
                        begin
                            first_ref_next = in_ch.in_byte;
                            phase_next     = PH_REF2;
                        end
                    end
                    default:
                    begin
                        flag_bits_next = in_ch.in_byte;
                        flag_pos_next  = '0;
                        phase_next     = PH_ITEM;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FLAG;
            flag_bits_reg  <= '0;
            flag_pos_reg   <= '0;
            first_ref_reg  <= '0;
            finished_reg   <= 1'b0;
            wp_reg         <= WP_START;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            copy_rem_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flag_pos_reg   <= flag_pos_next;
            first_ref_reg  <= first_ref_next;
            finished_reg   <= finished_next;
            wp_reg         <= wp_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            rd_pend_reg    <= rd_pend_next;
            hold_valid_reg <= hold_valid_next;
            fwd_hit_reg    <= fwd_hit_next;
            copy_rem_reg   <= copy_rem_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg      <= hold_next;
        fwd_data_reg  <= fwd_data_next;
        copy_off_reg  <= copy_off_next;
        out_byte_reg  <= out_byte_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ----- hdl/lzwd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, registered read data (read-old on collision).
// ----------------------------------------------------------------------------
module lzwd_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/lzwd_checker.sv -----
// ----------------------------------------------------------------------------
// LZSS window decompressor port checker
// Watches the top-level channels for ordering and stall behavior.
// ----------------------------------------------------------------------------
`include "lzss_window_decompressor_top_assert.svh"

module lzwd_checker
    import lzwd_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_ready,
    input logic  out_valid,
    input logic  out_ready,
    input byte_t out_byte,
    input logic  end_marker,
    input logic  run_last
);

    // stalled request keeps its payload
    `LZWD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(end_marker) && $stable(run_last), "stalled output changed")

    // a reference run delivers its bytes without gaps
    `LZWD_ASSERT_NEXT(a_run_no_gap, clk, rst_n, out_valid && out_ready && !run_last, out_valid, "gap inside a reference run")

    // no new input while a run is still being delivered
    `LZWD_ASSERT_NOW(a_no_input_mid_run, clk, rst_n, out_valid && !run_last, !(in_valid && in_ready), "input taken during a reference run")

    // end results carry a zero byte and close the run
    `LZWD_ASSERT_NOW(a_end_form, clk, rst_n, out_valid && end_marker, out_byte == 8'h00 && run_last, "malformed end result")

endmodule

bind lzss_window_decompressor_top lzwd_checker u_lzwd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .end_marker (out_ch.end_marker),
    .run_last   (out_ch.run_last)
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// LZSS window decompressor testbench
// Sends flag, literal and reference bytes in chunks, with directed corner
// cases first and then random chunks, and predicts every decompressed byte
// and end result from a private copy of the history window. Both handshakes
// idle at random, and output results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top
    import lzwd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN_DEPTH   = 4096;
    localparam int IDLE_LIMIT  = 20000;
    localparam int ITEM_TARGET = 380;
    localparam int DRAIN_EVERY = 60;

    typedef struct {
        byte_t data;
        logic  start;
        bit    drain;
    } byte_req_t;

    typedef struct packed {
        byte_t data;
        logic  endm;
        logic  last;
    } out_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b1;

    lzwd_in_if  in_ch ();
    lzwd_out_if out_ch ();

    lzss_window_decompressor_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stimulus and scoreboard storage
    byte_req_t pending_bytes [$];
    out_res_t  expected_out [$];
    int        n_planned;
    int        n_total;
    int        n_accepted;
    int        fail_count;
    bit        drain_next;
    logic [OFFSET_W-1:0] est_wp;

    // Predictor state
    byte_t               hist_mem [0:WIN_DEPTH-1];
    logic [OFFSET_W-1:0] wr_ptr;
    byte_t               tag_bits;
    logic [2:0]          tag_pos;
    phase_t              phase;
    byte_t               ref_lo;
    bit                  chunk_done;

    function automatic void step_tag();
        phase = (tag_pos == LAST_TAG) ? PH_FLAG : PH_ITEM;
        tag_pos = tag_pos + 3'd1;
    endfunction

    function automatic void put_hist(input byte_t v, input logic last);
        hist_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 1'b1;
        expected_out.push_back('{data: v, endm: 1'b0, last: last});
    endfunction

    // Work out the results that one accepted byte causes.
    function automatic void expand_request(input byte_t b, input logic s);
        logic [OFFSET_W-1:0] src;
        int                  len;
        byte_t               v;
        if (s)
        begin
            wr_ptr     = 1;
            tag_bits   = b;
            tag_pos    = 3'd0;
            phase      = PH_ITEM;
            chunk_done = 1'b0;
            return;
        end
        if (chunk_done)
            return;
        case (phase)
            PH_REF2:
            begin
                src = {b, ref_lo[7:4]};
                len = int'(ref_lo[3:0]) + 2;
                if (src == '0)
                begin
                    expected_out.push_back('{data: END_BYTE, endm: 1'b1, last: 1'b1});
                    chunk_done = 1'b1;
                    phase      = PH_FLAG;
                end
                else
                begin
                    // copy byte by byte: the source may catch up with fresh writes
                    for (int i = 0; i < len; i++)
                    begin
                        v = hist_mem[src];
                        put_hist(v, i == len - 1);
                        src = src + 1'b1;
                    end
                    step_tag();
                end
            end
            PH_ITEM:
            begin
                if (!tag_bits[tag_pos])
                begin
                    put_hist(b, 1'b1);
                    step_tag();
                end
                else
                begin
                    ref_lo = b;
                    phase  = PH_REF2;
                end
            end
            default:
            begin
                tag_bits = b;
                tag_pos  = 3'd0;
                phase    = PH_ITEM;
            end
        endcase
    endfunction

    task automatic add_req(input byte_t b, input logic s, input bit counted);
        pending_bytes.push_back('{data: b, start: s, drain: drain_next});
        drain_next = 1'b0;
        if (counted)
            n_planned++;
        if (s)
            est_wp = 1;
    endtask

    task automatic add_copy(input logic [3:0] len_code, input logic [OFFSET_W-1:0] off);
        add_req({off[3:0], len_code}, 1'b0, 1'b1);
        add_req(off[11:4], 1'b0, 1'b1);
        est_wp = est_wp + OFFSET_W'(len_code) + OFFSET_W'(2);
    endtask

    // Sender: one request per handshake, random gaps between requests
    int        tx_gap;
    bit        tx_calm;
    byte_req_t tx_next;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid       <= 1'b0;
            in_ch.in_byte     <= '0;
            in_ch.chunk_start <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expand_request(in_ch.in_byte, in_ch.chunk_start);
                n_accepted++;
                if ($urandom_range(0, 39) == 0)
                    tx_calm = !tx_calm;
                tx_gap = tx_calm ? 0 : $urandom_range(0, 4);
            end
            if ((in_ch.valid && in_ch.ready) || !in_ch.valid)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0 &&
                         !(pending_bytes[0].drain && expected_out.size() != 0))
                begin
                    tx_next = pending_bytes.pop_front();
                    in_ch.in_byte     <= tx_next.data;
                    in_ch.chunk_start <= tx_next.start;
                    in_ch.valid       <= 1'b1;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each result against the oldest prediction
    int       rx_hold;
    int       rx_next;
    bit       rx_calm;
    out_res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected result: out_byte=%02h end_marker=%0b run_last=%0b",
                           out_ch.out_byte, out_ch.end_marker, out_ch.run_last);
                    fail_count++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (out_ch.out_byte !== want.data)
                    begin
                        $error("out_byte: expected %02h, got %02h", want.data, out_ch.out_byte);
                        fail_count++;
                    end
                    if (out_ch.end_marker !== want.endm)
                    begin
                        $error("end_marker: expected %0b, got %0b",
                               want.endm, out_ch.end_marker);
                        fail_count++;
                    end
                    if (out_ch.run_last !== want.last)
                    begin
                        $error("run_last: expected %0b, got %0b", want.last, out_ch.run_last);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_calm = !rx_calm;
                rx_next = rx_calm ? 0 : $urandom_range(0, 4);
            end
            else
            begin
                rx_next = (rx_hold > 0) ? rx_hold - 1 : 0;
            end
            rx_hold = rx_next;
            out_ch.ready <= (rx_next == 0);
        end
    end

    // Watchdog: the window clearing pass after reset fits well inside the limit
    int idle_cycles;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        byte_t               flag;
        int                  groups;
        int                  cut;
        int                  tags_done;
        bit                  stop;
        logic [3:0]          len_code;
        logic [OFFSET_W-1:0] off;
        int                  next_drain;

        for (int i = 0; i < WIN_DEPTH; i++)
            hist_mem[i] = '0;
        wr_ptr      = 1;
        tag_bits    = '0;
        tag_pos     = 3'd0;
        phase       = PH_FLAG;
        ref_lo      = '0;
        chunk_done  = 1'b0;
        n_planned   = 0;
        n_accepted  = 0;
        fail_count  = 0;
        idle_cycles = 0;
        drain_next  = 1'b0;
        est_wp      = 1;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;

        // Directed part. First byte after reset, with no chunk start, is a flag.
        add_req(8'h02, 1'b0, 1'b1);
        add_req(8'hFF, 1'b0, 1'b1);
        // longest copy, one byte behind the write pointer: a run of the literal
        add_copy(4'hF, 12'h001);
        add_req(8'h00, 1'b0, 1'b1);
        add_req(8'h80, 1'b0, 1'b1);
        add_req(8'h7F, 1'b0, 1'b1);
        add_req(8'h55, 1'b0, 1'b1);
        add_req(8'hAA, 1'b0, 1'b1);
        add_req(8'h01, 1'b0, 1'b1);
        // all eight tags used: the next byte is a flag again, all references
        add_req(8'hFF, 1'b0, 1'b1);
        // shortest copy from the top of the window, wrapping to entry zero
        add_copy(4'h0, 12'hFFF);
        // first reference byte, then a chunk start cuts the reference
        add_req(8'h35, 1'b0, 1'b1);
        drain_next = 1'b1;
        add_req(8'h02, 1'b1, 1'b1);
        add_req(8'h42, 1'b0, 1'b1);
        // zero offset closes the chunk; later bytes are dropped
        add_copy(4'h0, 12'h000);
        add_req(8'h12, 1'b0, 1'b0);
        add_req(8'hFF, 1'b0, 1'b0);
        // chunk left open: the next chunk start restarts the parser
        add_req(8'h01, 1'b1, 1'b1);
        add_copy(4'h1, 12'h001);

        // Random chunks
        next_drain = n_planned + DRAIN_EVERY;
        while (n_planned < ITEM_TARGET)
        begin
            if (n_planned >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain += DRAIN_EVERY;
            end
            if ($urandom_range(0, 11) == 0)
            begin
                // noise: random bytes, now and then a chunk start among them
                add_req(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                repeat ($urandom_range(3, 10))
                    add_req(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b1);
                continue;
            end
            flag = 8'($urandom_range(0, 255));
            add_req(flag, 1'b1, 1'b1);
            groups    = $urandom_range(1, 3);
            cut       = ($urandom_range(0, 4) == 0) ? $urandom_range(0, groups * 8 - 1)
                                                    : groups * 8;
            tags_done = 0;
            stop      = 1'b0;
            for (int g = 0; g < groups && !stop; g++)
            begin
                if (g > 0)
                begin
                    flag = 8'($urandom_range(0, 255));
                    add_req(flag, 1'b0, 1'b1);
                end
                for (int t = 0; t < 8 && !stop; t++)
                begin
                    if (tags_done == cut)
                    begin
                        // leave a dangling first reference byte half the time
                        if (flag[t] && $urandom_range(0, 1) == 1)
                            add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                        stop = 1'b1;
                    end
                    else if (flag[t])
                    begin
                        len_code = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                               : 4'($urandom_range(0, 5));
                        case ($urandom_range(0, 3))
                            0, 1: off = est_wp - OFFSET_W'($urandom_range(1, 24));
                            2:    off = OFFSET_W'($urandom_range(1, WIN_DEPTH - 1));
                            default: off = est_wp + OFFSET_W'($urandom_range(1, 200));
                        endcase
                        if (off == '0)
                            off = 1;
                        add_copy(len_code, off);
                        tags_done++;
                    end
                    else
                    begin
                        add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                        est_wp = est_wp + 1'b1;
                        tags_done++;
                    end
                end
            end
            if (!stop)
            begin
                add_req({7'($urandom_range(0, 127)), 1'b1}, 1'b0, 1'b1);
                add_copy(4'($urandom_range(0, 15)), '0);
                repeat ($urandom_range(0, 2))
                    add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
        end
        n_total = pending_bytes.size();

        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted != n_total || expected_out.size() != 0)
            @(posedge clk);
        // hold a little longer to catch any stray result
        repeat (40) @(posedge clk);

        if (expected_out.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_out.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
